FILE: src/apt_pkg.sv
package apt_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int SH_W        = SUM_W - FRAC_BITS;
  localparam int WIDE_W      = SH_W + 2;
  localparam int NUM_W       = 2 * FRAC_BITS + 1;
  localparam int CNT_W       = $clog2(NUM_W + 1);
  localparam int REG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int IN_DATA_W   = 4 * DATA_W;
  localparam int OUT_DATA_W  = 2 * DATA_W;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [SH_W-1:0]   shr_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  // register indexes on the configuration port
  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEF_A   = 3'd0,
    REG_COEF_B   = 3'd1,
    REG_COEF_C   = 3'd2,
    REG_COEF_D   = 3'd3,
    REG_OFFSET_X = 3'd4,
    REG_OFFSET_Y = 3'd5
  } reg_idx_t;

  localparam logic ACT_INV = 1'b1;

  // matrix, offsets and the inverted matrix handed to the front end
  typedef struct packed {
    data_t a;
    data_t b;
    data_t c;
    data_t d;
    data_t ox;
    data_t oy;
    data_t ta;
    data_t tb;
    data_t tc;
    data_t td;
    logic  inv_sat;
    logic  sing;
  } cfg_view_t;

  // one classified word on its way to the arithmetic back end
  typedef struct packed {
    logic  inv;
    data_t m0;
    data_t m1;
    data_t m2;
    data_t m3;
    data_t px;
    data_t py;
    data_t t0;
    data_t t1;
    logic  sat;
    logic  sing;
  } item_t;

  // clamp to the signed data range, flag in the top bit
  function automatic logic [DATA_W:0] sat_data(input wide_t v);
    wide_t mx;
    wide_t mn;
    mx = {{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    mn = {{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    if (v > mx) return {1'b1, mx[DATA_W-1:0]};
    if (v < mn) return {1'b1, mn[DATA_W-1:0]};
    return {1'b0, v[DATA_W-1:0]};
  endfunction

endpackage

FILE: src/apt_inv.sv
module apt_inv (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [apt_pkg::REG_IDX_W-1:0]   cfg_addr,
  input  logic [apt_pkg::DATA_W-1:0]      cfg_wdata,
  output apt_pkg::cfg_view_t              cv,
  output logic                            busy
);
  import apt_pkg::*;

  typedef enum logic [2:0] {
    S_DET_MUL, S_DET_SUB, S_DIV, S_CLAMP, S_INV_MUL, S_INV_SAT, S_IDLE
  } state_t;

  state_t state_r;
  data_t a_r, b_r, c_r, d_r, ox_r, oy_r;
  data_t ta_r, tb_r, tc_r, td_r, dd_r;
  prod_t pad_r, pbc_r, pa_r, pb_r, pc_r, pd_r;
  logic [SH_W-1:0] mag_r;
  logic [SH_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic neg_r, sing_r, sat_r;

  sum_t det_sum;
  shr_t det;
  logic [SH_W:0] trial;
  logic [SH_W-1:0] rem_nxt;
  logic quo_bit;
  logic [PROD_W-1:0] quo_ext, lim;
  logic [DATA_W:0] q_clamp;
  logic [DATA_W:0] dd_ext;
  sum_t nb_sum, nc_sum;
  shr_t sa, sb, sc, sd;
  logic [DATA_W:0] ra, rb, rc, rd;

  // determinant, one divider step, clamps of the inverted entries
  always_comb begin
    det_sum = SUM_W'(pad_r) - SUM_W'(pbc_r);
    det     = det_sum[SUM_W-1:FRAC_BITS];
    trial   = {rem_r, (cnt_r == '0)};
    quo_bit = (trial >= {1'b0, mag_r});
    rem_nxt = quo_bit ? SH_W'(trial - {1'b0, mag_r}) : trial[SH_W-1:0];
    quo_ext = {{(PROD_W-NUM_W){1'b0}}, quo_r};
    lim     = neg_r ? PROD_W'(64'h8000_0000) : PROD_W'(64'h7FFF_FFFF);
    q_clamp = (quo_ext > lim) ? lim[DATA_W:0] : quo_r[DATA_W:0];
    dd_ext  = neg_r ? -q_clamp : q_clamp;
    nb_sum  = -SUM_W'(pb_r);
    nc_sum  = -SUM_W'(pc_r);
    sd      = SH_W'($signed(pd_r[PROD_W-1:FRAC_BITS]));
    sa      = SH_W'($signed(pa_r[PROD_W-1:FRAC_BITS]));
    sb      = nb_sum[SUM_W-1:FRAC_BITS];
    sc      = nc_sum[SUM_W-1:FRAC_BITS];
    ra      = sat_data(WIDE_W'(sd));
    rb      = sat_data(WIDE_W'(sb));
    rc      = sat_data(WIDE_W'(sc));
    rd      = sat_data(WIDE_W'(sa));
  end

  // register file and setup sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_DET_MUL;
      a_r  <= data_t'(1 << FRAC_BITS);
      b_r  <= '0;
      c_r  <= '0;
      d_r  <= data_t'(1 << FRAC_BITS);
      ox_r <= '0;
      oy_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        state_r <= S_DET_MUL;
        case (cfg_addr)
          REG_COEF_A:   a_r  <= cfg_wdata;
          REG_COEF_B:   b_r  <= cfg_wdata;
          REG_COEF_C:   c_r  <= cfg_wdata;
          REG_COEF_D:   d_r  <= cfg_wdata;
          REG_OFFSET_X: ox_r <= cfg_wdata;
          REG_OFFSET_Y: oy_r <= cfg_wdata;
          default: ;
        endcase
      end else begin
        case (state_r)
          S_DET_MUL: begin
            pad_r   <= a_r * d_r;
            pbc_r   <= b_r * c_r;
            state_r <= S_DET_SUB;
          end
          S_DET_SUB: begin
            neg_r   <= det[SH_W-1];
            mag_r   <= det[SH_W-1] ? SH_W'(-det) : det;
            sing_r  <= (det == '0);
            sat_r   <= 1'b0;
            rem_r   <= '0;
            quo_r   <= '0;
            cnt_r   <= '0;
            state_r <= (det == '0) ? S_CLAMP : S_DIV;
          end
          S_DIV: begin
            rem_r <= rem_nxt;
            quo_r <= {quo_r[NUM_W-2:0], quo_bit};
            cnt_r <= cnt_r + 1'b1;
            if (cnt_r == CNT_W'(NUM_W - 1)) state_r <= S_CLAMP;
          end
          S_CLAMP: begin
            if (sing_r) begin
              dd_r <= data_t'(1 << FRAC_BITS);
            end else begin
              dd_r  <= dd_ext[DATA_W-1:0];
              sat_r <= (quo_ext > lim);
            end
            state_r <= S_INV_MUL;
          end
          S_INV_MUL: begin
            pa_r <= a_r * dd_r;
            pb_r <= b_r * dd_r;
            pc_r <= c_r * dd_r;
            pd_r <= d_r * dd_r;
            state_r <= S_INV_SAT;
          end
          S_INV_SAT: begin
            ta_r  <= ra[DATA_W-1:0];
            tb_r  <= rb[DATA_W-1:0];
            tc_r  <= rc[DATA_W-1:0];
            td_r  <= rd[DATA_W-1:0];
            sat_r <= sat_r | ra[DATA_W] | rb[DATA_W] | rc[DATA_W] | rd[DATA_W];
            state_r <= S_IDLE;
          end
          S_IDLE: ;
          default: state_r <= S_DET_MUL;
        endcase
      end
    end
  end

  assign busy = (state_r != S_IDLE);
  assign cv = '{a: a_r, b: b_r, c: c_r, d: d_r, ox: ox_r, oy: oy_r,
                ta: ta_r, tb: tb_r, tc: tc_r, td: td_r,
                inv_sat: sat_r, sing: sing_r};

endmodule

FILE: src/apt_front.sv
module apt_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [apt_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tuser,
  input  apt_pkg::cfg_view_t               cv,
  input  logic                             setup_busy,
  output logic                             f_valid,
  output apt_pkg::item_t                   f_item,
  input  logic                             f_ready
);
  import apt_pkg::*;

  logic  f_valid_r;
  item_t f_item_r;
  item_t item_nxt;
  data_t px, py, gx, gy;
  logic [DATA_W:0] tx, ty;

  // split the word and pick coefficients by action
  always_comb begin
    px = in_tdata[DATA_W-1:0];
    py = in_tdata[2*DATA_W-1:DATA_W];
    gx = in_tdata[3*DATA_W-1:2*DATA_W];
    gy = in_tdata[4*DATA_W-1:3*DATA_W];
    tx = sat_data(WIDE_W'(cv.ox) + WIDE_W'(gx));
    ty = sat_data(WIDE_W'(cv.oy) + WIDE_W'(gy));
    item_nxt.inv = (in_tuser == ACT_INV);
    item_nxt.px  = px;
    item_nxt.py  = py;
    if (in_tuser == ACT_INV) begin
      item_nxt.m0   = cv.ta;
      item_nxt.m1   = cv.tc;
      item_nxt.m2   = cv.tb;
      item_nxt.m3   = cv.td;
      item_nxt.t0   = tx[DATA_W-1:0];
      item_nxt.t1   = ty[DATA_W-1:0];
      item_nxt.sat  = cv.inv_sat | tx[DATA_W] | ty[DATA_W];
      item_nxt.sing = cv.sing;
    end else begin
      item_nxt.m0   = cv.a;
      item_nxt.m1   = cv.c;
      item_nxt.m2   = cv.b;
      item_nxt.m3   = cv.d;
      item_nxt.t0   = cv.ox;
      item_nxt.t1   = cv.oy;
      item_nxt.sat  = 1'b0;
      item_nxt.sing = 1'b0;
    end
  end

  assign in_tready = !setup_busy && (!f_valid_r || f_ready);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        f_valid_r <= 1'b1;
        f_item_r  <= item_nxt;
      end else if (f_ready) begin
        f_valid_r <= 1'b0;
      end
    end
  end

  assign f_valid = f_valid_r;
  assign f_item  = f_item_r;

endmodule

FILE: src/apt_queue.sv
module apt_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  apt_pkg::item_t    wr_item,
  output logic              rd_valid,
  input  logic              rd_en,
  output apt_pkg::item_t    rd_item
);
  import apt_pkg::*;

  item_t mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;
  logic push, pop;

  assign wr_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_en && rd_valid;
  assign rd_item  = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_item;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

FILE: src/apt_back.sv
module apt_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  apt_pkg::item_t                    q_item,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [apt_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [1:0]                        out_tuser
);
  import apt_pkg::*;

  logic en;
  // stage 1: products
  logic  s1_valid_r, s1_inv_r, s1_sat_r, s1_sing_r;
  prod_t p0_r, p1_r, p2_r, p3_r, q0_r, q1_r, q2_r, q3_r;
  data_t s1_t0_r, s1_t1_r;
  // stage 2: shifted sums and translation terms
  logic  s2_valid_r, s2_sat_r, s2_sing_r;
  shr_t  sx_r, sy_r;
  wide_t tx_r, ty_r;
  // output register
  logic  o_valid_r, o_sat_r, o_sing_r;
  data_t o_x_r, o_y_r;

  sum_t  sum_x, sum_y, sum_qx, sum_qy;
  shr_t  sx, sy, sqx, sqy;
  wide_t rx, ry;
  logic [DATA_W:0] cx, cy;

  assign en    = !o_valid_r || out_tready;
  assign q_pop = en && q_valid;

  always_comb begin
    sum_x  = SUM_W'(p0_r) + SUM_W'(p1_r);
    sum_y  = SUM_W'(p2_r) + SUM_W'(p3_r);
    sum_qx = SUM_W'(q0_r) + SUM_W'(q1_r);
    sum_qy = SUM_W'(q2_r) + SUM_W'(q3_r);
    sx  = sum_x[SUM_W-1:FRAC_BITS];
    sy  = sum_y[SUM_W-1:FRAC_BITS];
    sqx = sum_qx[SUM_W-1:FRAC_BITS];
    sqy = sum_qy[SUM_W-1:FRAC_BITS];
    rx  = WIDE_W'(sx_r) + tx_r;
    ry  = WIDE_W'(sy_r) + ty_r;
    cx  = sat_data(rx);
    cy  = sat_data(ry);
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else if (en) begin
      s1_valid_r <= q_valid;
      s2_valid_r <= s1_valid_r;
      o_valid_r  <= s2_valid_r;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= q_item.m0 * q_item.px;
      p1_r <= q_item.m1 * q_item.py;
      p2_r <= q_item.m2 * q_item.px;
      p3_r <= q_item.m3 * q_item.py;
      q0_r <= q_item.m0 * q_item.t0;
      q1_r <= q_item.m1 * q_item.t1;
      q2_r <= q_item.m2 * q_item.t0;
      q3_r <= q_item.m3 * q_item.t1;
      s1_t0_r   <= q_item.t0;
      s1_t1_r   <= q_item.t1;
      s1_inv_r  <= q_item.inv;
      s1_sat_r  <= q_item.sat;
      s1_sing_r <= q_item.sing;

      sx_r <= sx;
      sy_r <= sy;
      tx_r <= s1_inv_r ? -WIDE_W'(sqx) : WIDE_W'(s1_t0_r);
      ty_r <= s1_inv_r ? -WIDE_W'(sqy) : WIDE_W'(s1_t1_r);
      s2_sat_r  <= s1_sat_r;
      s2_sing_r <= s1_sing_r;

      o_x_r    <= cx[DATA_W-1:0];
      o_y_r    <= cy[DATA_W-1:0];
      o_sat_r  <= s2_sat_r | cx[DATA_W] | cy[DATA_W];
      o_sing_r <= s2_sing_r;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = {o_y_r, o_x_r};
  assign out_tuser  = {o_sing_r, o_sat_r};

endmodule

FILE: src/affine_point_transform_top.sv
// Affine point transform: x' = a*x + c*y + tx, y' = b*x + d*y + ty in signed
// Q16.16, or the inverse map with the word's origin added to the translation.
// After reset and after every configuration write the block builds the
// inverted matrix: S_DET_MUL, S_DET_SUB, a 33-step restoring divider for
// 1/det (one bit per cycle; skipped when det is zero), S_CLAMP, S_INV_MUL
// and S_INV_SAT; in_tready stays low meanwhile.
// Once set up it takes one point per cycle while the output is not stalled,
// and a point accepted into the input register then passes the queue write,
// product stage, sum stage and output register; a four-word queue lets input
// and output stall independently.
module affine_point_transform_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // point_x, point_y, origin_x, origin_y
  input  logic [apt_pkg::IN_DATA_W-1:0]     in_tdata,
  // action
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // result_x, result_y
  output logic [apt_pkg::OUT_DATA_W-1:0]    out_tdata,
  // saturated, singular
  output logic [1:0]                        out_tuser,
  input  logic                              cfg_wr_en,
  input  logic [apt_pkg::REG_IDX_W-1:0]     cfg_addr,
  input  logic [apt_pkg::DATA_W-1:0]        cfg_wdata
);
  import apt_pkg::*;

  cfg_view_t cv;
  logic      setup_busy;
  logic      f_valid, f_ready;
  item_t     f_item;
  logic      q_valid, q_pop;
  item_t     q_item;

  apt_inv u_inv (
    .clk, .rst_n, .cfg_wr_en, .cfg_addr, .cfg_wdata,
    .cv, .busy(setup_busy)
  );

  apt_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .cv, .setup_busy, .f_valid, .f_item, .f_ready
  );

  apt_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
    .rd_valid(q_valid), .rd_en(q_pop), .rd_item(q_item)
  );

  apt_back u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

endmodule

FILE: src/apt_checker.sv
module apt_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [apt_pkg::OUT_DATA_W-1:0]    out_tdata,
  input logic                              cfg_wr_en
);

  // setup pass follows reset
  a_reset_setup: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input ready right after reset");

  // a register write restarts setup
  a_cfg_setup: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> !in_tready)
    else $error("input ready right after a register write");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed while stalled");

endmodule

bind affine_point_transform_top apt_checker u_apt_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .cfg_wr_en
);

FILE: sim/tb_affine_point_transform_top.sv
module tb_affine_point_transform_top;
  import apt_pkg::*;

  localparam int FRAC = apt_pkg::FRAC_BITS;
  // index past the six registers, must be ignored
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd6;

  typedef logic signed [127:0] big_t;

  typedef struct {
    logic  act;
    data_t px;
    data_t py;
    data_t ox;
    data_t oy;
  } point_word_t;

  typedef struct {
    data_t rx;
    data_t ry;
    logic  sat;
    logic  sing;
  } xform_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_wr_en = 1'b0;
  logic [REG_IDX_W-1:0] cfg_addr = '0;
  logic [DATA_W-1:0] cfg_wdata = '0;

  // local copy of the matrix registers
  data_t m_a = 32'sd65536, m_b = '0, m_c = '0, m_d = 32'sd65536, m_ox = '0, m_oy = '0;

  point_word_t pending_points[$];
  xform_t      expected_points[$];
  logic        failed = 1'b0;
  logic        took_word = 1'b0;
  int          ready_pct = 100;
  int          hold_asked = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          burst_left = 0;
  int          gap_left = 0;

  affine_point_transform_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // clamp to 32 bits, raising the flag on a clamp
  function automatic big_t clamp32(input big_t v, inout logic flag);
    if (v > big_t'(32'sh7fffffff)) begin
      flag = 1'b1;
      return big_t'(32'sh7fffffff);
    end
    if (v < -big_t'(64'sh80000000)) begin
      flag = 1'b1;
      return -big_t'(64'sh80000000);
    end
    return v;
  endfunction

  // expected output for one point under the current matrix
  function automatic xform_t transform_point(input point_word_t w);
    big_t a, b, c, d, x, y, tx, ty, det, dd, mag, q, lim, ta, tb, tc, td, rx, ry;
    xform_t r;
    logic sat;
    a = m_a; b = m_b; c = m_c; d = m_d;
    x = w.px; y = w.py;
    sat = 1'b0;
    r.sing = 1'b0;
    if (w.act != ACT_INV) begin
      rx = ((a * x + c * y) >>> FRAC) + big_t'(m_ox);
      ry = ((b * x + d * y) >>> FRAC) + big_t'(m_oy);
    end else begin
      tx = clamp32(big_t'(m_ox) + big_t'(w.ox), sat);
      ty = clamp32(big_t'(m_oy) + big_t'(w.oy), sat);
      det = (a * d - b * c) >>> FRAC;
      if (det == 0) begin
        r.sing = 1'b1;
        dd = big_t'(1) <<< FRAC;
      end else begin
        mag = (det < 0) ? -det : det;
        q = (big_t'(1) <<< (2 * FRAC)) / mag;
        lim = (det < 0) ? big_t'(64'h80000000) : big_t'(64'h7fffffff);
        if (q > lim) begin
          q = lim;
          sat = 1'b1;
        end
        dd = (det < 0) ? -q : q;
      end
      ta = clamp32((d * dd) >>> FRAC, sat);
      tb = clamp32((-(b * dd)) >>> FRAC, sat);
      tc = clamp32((-(c * dd)) >>> FRAC, sat);
      td = clamp32((a * dd) >>> FRAC, sat);
      rx = ((ta * x + tc * y) >>> FRAC) - ((ta * tx + tc * ty) >>> FRAC);
      ry = ((tb * x + td * y) >>> FRAC) - ((tb * tx + td * ty) >>> FRAC);
    end
    rx = clamp32(rx, sat);
    ry = clamp32(ry, sat);
    r.rx = rx[31:0];
    r.ry = ry[31:0];
    r.sat = sat;
    return r;
  endfunction

  // sender: bursts of words with random gaps
  always @(negedge clk) begin
    point_word_t w;
    if (!in_tvalid || took_word) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        w = pending_points.pop_front();
        in_tdata <= {w.oy, w.ox, w.py, w.px};
        in_tuser <= w.act;
        in_tvalid <= 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold on request
  always @(negedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  // predict on accepted words, check returned words
  always @(posedge clk) begin
    point_word_t w;
    xform_t e;
    took_word = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        w.act = in_tuser;
        w.px = in_tdata[31:0];
        w.py = in_tdata[63:32];
        w.ox = in_tdata[95:64];
        w.oy = in_tdata[127:96];
        expected_points.push_back(transform_point(w));
        took_word = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        if (expected_points.size() == 0) begin
          $error("result word with no expected point pending");
          failed = 1'b1;
        end else begin
          e = expected_points.pop_front();
          if (out_tdata[31:0] !== e.rx) begin
            $error("result_x expected %h got %h", e.rx, out_tdata[31:0]);
            failed = 1'b1;
          end
          if (out_tdata[63:32] !== e.ry) begin
            $error("result_y expected %h got %h", e.ry, out_tdata[63:32]);
            failed = 1'b1;
          end
          if (out_tuser[0] !== e.sat) begin
            $error("saturated expected %b got %b", e.sat, out_tuser[0]);
            failed = 1'b1;
          end
          if (out_tuser[1] !== e.sing) begin
            $error("singular expected %b got %b", e.sing, out_tuser[1]);
            failed = 1'b1;
          end
        end
      end
    end
  end

  task automatic add_point(input logic act, input data_t x, input data_t y,
                           input data_t ox, input data_t oy);
    point_word_t w;
    w.act = act; w.px = x; w.py = y; w.ox = ox; w.oy = oy;
    pending_points.push_back(w);
  endtask

  // mix of full random, small fixed point, extremes and round values
  function automatic data_t rnd_q16();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 524288)) - 262144;
      2: return ($urandom_range(0, 1) == 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return ($urandom_range(0, 1) == 1) ? 32'sd65536 : -32'sd65536;
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_points.size() > 0 || in_tvalid || expected_points.size() > 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input data_t v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    case (idx)
      REG_COEF_A:   m_a = v;
      REG_COEF_B:   m_b = v;
      REG_COEF_C:   m_c = v;
      REG_COEF_D:   m_d = v;
      REG_OFFSET_X: m_ox = v;
      REG_OFFSET_Y: m_oy = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic load_matrix(input data_t a, input data_t b, input data_t c,
                             input data_t d, input data_t ox, input data_t oy);
    wait_drained();
    write_reg(REG_COEF_A, a);
    write_reg(REG_COEF_B, b);
    write_reg(REG_COEF_C, c);
    write_reg(REG_COEF_D, d);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_UNUSED, $urandom);
  endtask

  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // identity after reset, field extremes in both modes
    add_point(1'b0, 32'sh7fffffff, 32'sh80000000, '0, '0);
    add_point(1'b0, 32'sh80000000, 32'sh7fffffff, '0, '0);
    add_point(1'b0, '0, '0, '0, '0);
    add_point(1'b1, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    add_point(1'b1, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    add_point(1'b1, 32'sd65536, -32'sd65536, 32'sd131072, '0);
    add_point(1'b1, 32'shffffffff, 32'sh00000001, 32'shffffffff, 32'sh00000001);

    // zero matrix: singular in inverse mode
    load_matrix('0, '0, '0, '0, 32'sh7fffffff, 32'sh80000000);
    add_point(1'b1, 32'sd65536, 32'sd65536, 32'sd1, -32'sd1);
    add_point(1'b0, 32'sd65536, 32'sd65536, '0, '0);
    add_point(1'b1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);

    // register extremes, forward results clamp
    load_matrix(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                32'sh7fffffff, 32'sh80000000);
    add_point(1'b0, 32'sh7fffffff, 32'sh7fffffff, '0, '0);
    add_point(1'b0, 32'sh80000000, 32'sh80000000, '0, '0);
    add_point(1'b1, 32'sd65536, 32'sd3, 32'sh80000000, 32'sh7fffffff);

    // determinant rounds to zero in fixed point
    load_matrix(32'sd2, '0, '0, 32'sd2, '0, '0);
    add_point(1'b1, 32'sd65536, -32'sd65536, 32'sd5, 32'sd7);
    // tiny determinant: reciprocal clamps
    load_matrix(32'sd256, '0, '0, 32'sd256, 32'sd65536, '0);
    add_point(1'b1, 32'sd65536, -32'sd65536, '0, '0);
    add_point(1'b1, 32'sd1, 32'sd1, '0, '0);
    // negative determinant with shear
    load_matrix('0, 32'sd65536, 32'sd65536, '0, 32'sd100, -32'sd100);
    add_point(1'b1, 32'sd12345, -32'sd777, 32'sd9, 32'sd9);
    add_point(1'b0, 32'sd12345, -32'sd777, '0, '0);

    // random phases, each with its own matrix
    for (int ph = 0; ph < 21; ph++) begin
      load_matrix(rnd_q16(), rnd_q16(), rnd_q16(), rnd_q16(), rnd_q16(), rnd_q16());
      case (ph % 4)
        0: ready_pct = 100;
        1: ready_pct = 70;
        2: ready_pct = 35;
        default: ready_pct = $urandom_range(10, 95);
      endcase
      if (ph == 5) hold_asked++;
      for (int i = 0; i < 54; i++)
        add_point(1'($urandom_range(0, 1)), rnd_q16(), rnd_q16(), rnd_q16(), rnd_q16());
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (failed) begin
      $display("status: fail");
    end else begin
      $display("status: pass");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/apt_pkg.sv
src/apt_inv.sv
src/apt_front.sv
src/apt_queue.sv
src/apt_back.sv
src/affine_point_transform_top.sv
src/apt_checker.sv
sim/tb_affine_point_transform_top.sv
